>>> rtl/core/spbps_pkg.sv
// shared types and constants for the split point best prefix/suffix block
// no dependencies
package spbps_pkg;

  localparam int CHR_W = 8;
  localparam int POS_W = 32;
  localparam int VAL_W = 32;
  localparam int SUM_W = 40;
  localparam int COL_W = 3;
  localparam int NCOLS = 4;

  // 1-based column numbers as reported on the result channel
  localparam logic [COL_W-1:0] COL_A = 3'd1;
  localparam logic [COL_W-1:0] COL_B = 3'd2;
  localparam logic [COL_W-1:0] COL_C = 3'd3;
  localparam logic [COL_W-1:0] COL_D = 3'd4;

  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [COL_W-1:0]        col_t;

  // controls from the sequencer to every column lane
  typedef struct packed {
    logic acc_en;   // add the row value and store the running sum
    logic clear;    // run finished, zero the column total
    logic sub_en;   // capture upstream and downstream sums of the read row
  } lane_ctl_t;

endpackage

>>> rtl/core/spbps_lane.sv
// one column lane: running total, prefix sum memory and suffix subtract
// depends on spbps_pkg
module spbps_lane
  import spbps_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int IDX_W = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  lane_ctl_t        ctl,
  input  val_t             value,
  input  logic [IDX_W-1:0] waddr,
  input  logic [IDX_W-1:0] raddr,
  output sum_t             up,
  output sum_t             down
);

  sum_t total;
  sum_t total_next;
  sum_t prefix_q;
  sum_t mem [DEPTH];

  assign total_next = total + SUM_W'(value);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      total <= '0;
    end else if (ctl.acc_en) begin
      total <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.acc_en) begin
      mem[waddr] <= total_next;
    end
    prefix_q <= mem[raddr];
  end

  // downstream sum is the run total minus the prefix
  always_ff @(posedge clk) begin
    if (ctl.sub_en) begin
      up   <= prefix_q;
      down <= total - prefix_q;
    end
  end

endmodule

>>> rtl/core/spbps_merge.sv
// merges the four lane sums into the best value and its column, first wins ties
// depends on spbps_pkg
module spbps_merge
  import spbps_pkg::*;
(
  input  logic clk,
  input  logic load,
  input  sum_t s0,
  input  sum_t s1,
  input  sum_t s2,
  input  sum_t s3,
  output sum_t best,
  output col_t col
);

  sum_t lo_best;
  sum_t hi_best;
  col_t lo_col;
  col_t hi_col;

  // pairwise stage, registered
  always_ff @(posedge clk) begin
    if (load) begin
      if (s1 > s0) begin
        lo_best <= s1;
        lo_col  <= COL_B;
      end else begin
        lo_best <= s0;
        lo_col  <= COL_A;
      end
      if (s3 > s2) begin
        hi_best <= s3;
        hi_col  <= COL_D;
      end else begin
        hi_best <= s2;
        hi_col  <= COL_C;
      end
    end
  end

  // final pick, lower pair wins on ties
  always_comb begin
    if (hi_best > lo_best) begin
      best = hi_best;
      col  = hi_col;
    end else begin
      best = lo_best;
      col  = lo_col;
    end
  end

endmodule

>>> rtl/core/split_point_best_prefix_suffix.sv
// top level of the split point best prefix/suffix block
// depends on spbps_pkg, spbps_lane and spbps_merge
//
// usage:
//   rows come in on the input channel (in_valid/in_ready), one transfer per
//   cycle while loading. each row is summed into four column lanes and its
//   running prefix sums and position are stored. a row with last_row set
//   ends the run and starts the emit walk; in_ready stays low during the walk.
//   rows beyond MAX_ROWS are dropped, a dropped last row still starts the walk.
//   results leave on the output channel (out_valid/out_ready), one per stored
//   row in row order, last_result set on the final one.
// walk:
//   each result passes through memory read, suffix subtract, pairwise
//   compare and final compare into the output register; the walk starts the
//   next result only once the previous one has left the final compare step.
// stall:
//   the output register holds its result while out_ready is low and the walk
//   waits in the final compare step; nothing is lost.
// reset:
//   synchronous, active high. clears the sequencer, row count, column totals
//   and output valid. the stores need no clearing, the walk only reads rows
//   written in the current run.
module split_point_best_prefix_suffix
  import spbps_pkg::*;
#(
  parameter int MAX_ROWS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CHR_W-1:0] chromosome,
  input  logic [POS_W-1:0] position,
  input  val_t             value_a,
  input  val_t             value_b,
  input  val_t             value_c,
  input  val_t             value_d,
  input  logic             last_row,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [CHR_W-1:0] chromosome_out,
  output logic [POS_W-1:0] split_position,
  output sum_t             upstream_best,
  output sum_t             downstream_best,
  output col_t             upstream_column,
  output col_t             downstream_column,
  output logic             last_result
);

  localparam int IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CNT_W = $clog2(MAX_ROWS + 1);

  // sequencer states
  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_SUB  = 3'd2;
  localparam logic [2:0] S_MRG1 = 3'd3;
  localparam logic [2:0] S_MRG2 = 3'd4;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [CNT_W-1:0] row_count;
  logic [IDX_W-1:0] idx;
  logic [CHR_W-1:0] first_chromosome;
  logic [POS_W-1:0] pos_q;
  logic [POS_W-1:0] pos_mem [MAX_ROWS];

  logic      in_xfer;
  logic      store_row;
  logic      walk_last;
  logic      out_load;
  lane_ctl_t lane_ctl;

  sum_t up0, up1, up2, up3;
  sum_t dn0, dn1, dn2, dn3;
  sum_t up_best, dn_best;
  col_t up_col, dn_col;

  assign in_ready  = (state == S_LOAD);
  assign in_xfer   = in_valid && in_ready;
  assign store_row = in_xfer && (row_count < CNT_W'(MAX_ROWS));
  // current split point is the final stored row
  assign walk_last = (CNT_W'(idx) + CNT_W'(1)) == row_count;
  // final compare can move into the output register once it is free
  assign out_load  = (state == S_MRG2) && (!out_valid || out_ready);

  assign lane_ctl.acc_en = store_row;
  assign lane_ctl.clear  = out_load && walk_last;
  assign lane_ctl.sub_en = (state == S_SUB);

  always_comb begin
    state_next = state;
    case (state)
      S_LOAD: begin
        if (in_xfer && last_row) begin
          state_next = S_RD;
        end
      end
      S_RD:   state_next = S_SUB;
      S_SUB:  state_next = S_MRG1;
      S_MRG1: state_next = S_MRG2;
      S_MRG2: begin
        if (out_load) begin
          state_next = walk_last ? S_LOAD : S_RD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_LOAD;
      row_count        <= '0;
      idx              <= '0;
      first_chromosome <= '0;
    end else begin
      state <= state_next;
      if (store_row) begin
        row_count <= row_count + CNT_W'(1);
        if (row_count == '0) begin
          first_chromosome <= chromosome;
        end
      end
      if (out_load) begin
        if (walk_last) begin
          // run done, back to an empty store
          row_count        <= '0;
          idx              <= '0;
          first_chromosome <= '0;
        end else begin
          idx <= idx + IDX_W'(1);
        end
      end
    end
  end

  // position store, read at the walk index
  always_ff @(posedge clk) begin
    if (store_row) begin
      pos_mem[row_count[IDX_W-1:0]] <= position;
    end
    pos_q <= pos_mem[idx];
  end

  spbps_lane #(.DEPTH(MAX_ROWS), .IDX_W(IDX_W)) u_lane_a (
    .clk(clk), .rst(rst), .ctl(lane_ctl), .value(value_a),
    .waddr(row_count[IDX_W-1:0]), .raddr(idx), .up(up0), .down(dn0)
  );

  spbps_lane #(.DEPTH(MAX_ROWS), .IDX_W(IDX_W)) u_lane_b (
    .clk(clk), .rst(rst), .ctl(lane_ctl), .value(value_b),
    .waddr(row_count[IDX_W-1:0]), .raddr(idx), .up(up1), .down(dn1)
  );

  spbps_lane #(.DEPTH(MAX_ROWS), .IDX_W(IDX_W)) u_lane_c (
    .clk(clk), .rst(rst), .ctl(lane_ctl), .value(value_c),
    .waddr(row_count[IDX_W-1:0]), .raddr(idx), .up(up2), .down(dn2)
  );

  spbps_lane #(.DEPTH(MAX_ROWS), .IDX_W(IDX_W)) u_lane_d (
    .clk(clk), .rst(rst), .ctl(lane_ctl), .value(value_d),
    .waddr(row_count[IDX_W-1:0]), .raddr(idx), .up(up3), .down(dn3)
  );

  // upstream and downstream merges share the same schedule
  spbps_merge u_merge_up (
    .clk(clk), .load(state == S_MRG1),
    .s0(up0), .s1(up1), .s2(up2), .s3(up3),
    .best(up_best), .col(up_col)
  );

  spbps_merge u_merge_dn (
    .clk(clk), .load(state == S_MRG1),
    .s0(dn0), .s1(dn1), .s2(dn2), .s3(dn3),
    .best(dn_best), .col(dn_col)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      chromosome_out    <= first_chromosome;
      split_position    <= pos_q;
      upstream_best     <= up_best;
      downstream_best   <= dn_best;
      upstream_column   <= up_col;
      downstream_column <= dn_col;
      last_result       <= walk_last;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    row_count <= CNT_W'(MAX_ROWS))
    else $error("row count beyond store depth");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_LOAD) |-> (CNT_W'(idx) < row_count))
    else $error("walk index outside stored rows");

  a_walk_start: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && last_row) |=> (state == S_RD) && (row_count != '0))
    else $error("last row did not start a walk over stored rows");

  a_walk_end: assert property (@(posedge clk) disable iff (rst)
    (out_load && walk_last) |=> (state == S_LOAD) && (row_count == '0) && out_valid)
    else $error("run not closed after final result");
`endif

endmodule

>>> sim/split_point_checker.sv
// result checker for split_point_best_prefix_suffix: watches both channels,
// keeps its own copy of the run state and compares every result transfer
// depends on spbps_pkg for widths, sum/column types and column codes
module split_point_checker
  import spbps_pkg::*;
#(
  parameter int MAX_ROWS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [CHR_W-1:0] chromosome,
  input  logic [POS_W-1:0] position,
  input  val_t             value_a,
  input  val_t             value_b,
  input  val_t             value_c,
  input  val_t             value_d,
  input  logic             last_row,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [CHR_W-1:0] chromosome_out,
  input  logic [POS_W-1:0] split_position,
  input  sum_t             upstream_best,
  input  sum_t             downstream_best,
  input  col_t             upstream_column,
  input  col_t             downstream_column,
  input  logic             last_result,
  output int               mismatches,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [CHR_W-1:0] chrom;
    logic [POS_W-1:0] pos;
    sum_t             up_best;
    sum_t             down_best;
    col_t             up_col;
    col_t             down_col;
    logic             final_split;
  } split_result_t;

  // running state of the current run
  sum_t             row_prefix [MAX_ROWS][NCOLS];
  logic [POS_W-1:0] row_pos [MAX_ROWS];
  sum_t             run_total [NCOLS];
  logic [CHR_W-1:0] run_chrom;
  int               row_count;

  split_result_t expected_splits [$];
  int            fail_count = 0;

  assign mismatches = fail_count;

  function automatic col_t col_code(int idx);
    case (idx)
      0:       return COL_A;
      1:       return COL_B;
      2:       return COL_C;
      default: return COL_D;
    endcase
  endfunction

  // first column holding the maximum wins
  function automatic int best_index(sum_t s0, sum_t s1, sum_t s2, sum_t s3);
    sum_t s [NCOLS];
    int   idx;
    s = '{s0, s1, s2, s3};
    idx = 0;
    for (int k = 1; k < NCOLS; k++) begin
      if (s[k] > s[idx]) idx = k;
    end
    return idx;
  endfunction

  task automatic clear_run();
    row_count = 0;
    run_chrom = '0;
    for (int k = 0; k < NCOLS; k++) run_total[k] = '0;
  endtask

  // accumulate one row; a last row queues one result per stored row
  task automatic absorb_row(logic [CHR_W-1:0] chrom, logic [POS_W-1:0] pos,
                            val_t a, val_t b, val_t c, val_t d, logic last);
    val_t          v [NCOLS];
    sum_t          up [NCOLS];
    sum_t          down [NCOLS];
    split_result_t r;
    int            ui;
    int            di;
    v = '{a, b, c, d};
    // rows past a full store are dropped
    if (row_count < MAX_ROWS) begin
      if (row_count == 0) run_chrom = chrom;
      row_pos[row_count] = pos;
      for (int k = 0; k < NCOLS; k++) begin
        run_total[k] = run_total[k] + sum_t'(v[k]);
        row_prefix[row_count][k] = run_total[k];
      end
      row_count++;
    end
    if (last) begin
      for (int i = 0; i < row_count; i++) begin
        for (int k = 0; k < NCOLS; k++) begin
          up[k]   = row_prefix[i][k];
          down[k] = run_total[k] - up[k];
        end
        ui = best_index(up[0], up[1], up[2], up[3]);
        di = best_index(down[0], down[1], down[2], down[3]);
        r.chrom       = run_chrom;
        r.pos         = row_pos[i];
        r.up_best     = up[ui];
        r.down_best   = down[di];
        r.up_col      = col_code(ui);
        r.down_col    = col_code(di);
        r.final_split = (i == row_count - 1);
        expected_splits.push_back(r);
      end
      clear_run();
    end
  endtask

  task automatic check_field(string field, logic signed [63:0] want,
                             logic signed [63:0] got);
    if (got !== want) begin
      fail_count++;
      $error("%s: expected %0d, got %0d", field, want, got);
    end
  endtask

  always @(posedge clk) begin
    split_result_t want;
    if (rst) begin
      clear_run();
      expected_splits.delete();
      pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_splits.size() == 0) begin
          fail_count++;
          $error("result transfer with nothing expected, split_position %0d",
                 split_position);
        end else begin
          want = expected_splits.pop_front();
          check_field("chromosome_out", want.chrom, chromosome_out);
          check_field("split_position", want.pos, split_position);
          check_field("upstream_best", want.up_best, upstream_best);
          check_field("downstream_best", want.down_best, downstream_best);
          check_field("upstream_column", want.up_col, upstream_column);
          check_field("downstream_column", want.down_col, downstream_column);
          check_field("last_result", want.final_split, last_result);
        end
      end
      if (in_valid && in_ready)
        absorb_row(chromosome, position, value_a, value_b, value_c, value_d, last_row);
      pending <= expected_splits.size();
    end
  end

endmodule

>>> sim/tb_top.sv
// testbench top for split_point_best_prefix_suffix: row stimulus, result sink
// with random back pressure, and the verdict
// depends on spbps_pkg, the block and split_point_checker
module tb_top
  import spbps_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   ROWS        = 64;
  localparam int   ROW_TARGET  = 420;     // stored rows in the random part
  localparam int   HOLD_AT     = 160;     // rows sent before the long sink stall
  localparam int   HOLD_CYCLES = 400;
  localparam int   DRAIN       = 40;      // quiet cycles after the last result
  localparam int   LIMIT       = 300000;  // watchdog
  localparam val_t V_MAX       = 32'sh7FFF_FFFF;
  localparam val_t V_MIN       = 32'sh8000_0000;

  logic             clk;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [CHR_W-1:0] chromosome = '0;
  logic [POS_W-1:0] position = '0;
  val_t             value_a = '0;
  val_t             value_b = '0;
  val_t             value_c = '0;
  val_t             value_d = '0;
  logic             last_row = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [CHR_W-1:0] chromosome_out;
  logic [POS_W-1:0] split_position;
  sum_t             upstream_best;
  sum_t             downstream_best;
  col_t             upstream_column;
  col_t             downstream_column;
  logic             last_result;

  int mismatches;
  int pending;
  int rows_sent = 0;    // every accepted row transfer
  int rows_stored = 0;  // accepted rows that fit in the store
  int cycle_count = 0;

  split_point_best_prefix_suffix #(
    .MAX_ROWS(ROWS)
  ) u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .chromosome       (chromosome),
    .position         (position),
    .value_a          (value_a),
    .value_b          (value_b),
    .value_c          (value_c),
    .value_d          (value_d),
    .last_row         (last_row),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .chromosome_out   (chromosome_out),
    .split_position   (split_position),
    .upstream_best    (upstream_best),
    .downstream_best  (downstream_best),
    .upstream_column  (upstream_column),
    .downstream_column(downstream_column),
    .last_result      (last_result)
  );

  split_point_checker #(
    .MAX_ROWS(ROWS)
  ) u_checker (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .chromosome       (chromosome),
    .position         (position),
    .value_a          (value_a),
    .value_b          (value_b),
    .value_c          (value_c),
    .value_d          (value_d),
    .last_row         (last_row),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .chromosome_out   (chromosome_out),
    .split_position   (split_position),
    .upstream_best    (upstream_best),
    .downstream_best  (downstream_best),
    .upstream_column  (upstream_column),
    .downstream_column(downstream_column),
    .last_result      (last_result),
    .mismatches       (mismatches),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog, counts every cycle from time zero
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // idle length: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // value styles: 0 full range, 1 extremes and unit values, 2 small q15.16,
  // 3 a mix of the others per value
  function automatic val_t pick_value(int style);
    if (style == 3) style = $urandom_range(0, 2);
    case (style)
      0: return val_t'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0:       return V_MAX;
          1:       return V_MIN;
          2:       return '0;
          3:       return -1;
          default: return 1;
        endcase
      end
      default: return val_t'($urandom_range(0, 32'h0020_0000)) - val_t'(32'h0010_0000);
    endcase
  endfunction

  // hold the row on the bus until the transfer happens; valid stays high
  // from here until the accepting edge
  task automatic send_row(logic [CHR_W-1:0] chrom, logic [POS_W-1:0] pos,
                          val_t a, val_t b, val_t c, val_t d, logic last);
    in_valid   <= 1'b1;
    chromosome <= chrom;
    position   <= pos;
    value_a    <= a;
    value_b    <= b;
    value_c    <= c;
    value_d    <= d;
    last_row   <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rows_sent++;
  endtask

  // optional idle stretch with valid low, then the row
  task automatic offer_row(bit no_gap, logic [CHR_W-1:0] chrom,
                           logic [POS_W-1:0] pos, val_t a, val_t b, val_t c,
                           val_t d, logic last);
    int gap;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    send_row(chrom, pos, a, b, c, d, last);
  endtask

  // one well-formed run of len rows, last_row on the final one; runs longer
  // than the store exercise the dropped-row path
  task automatic send_run(int len);
    val_t v [NCOLS];
    int   style;
    bit   fast;
    logic [NCOLS-1:0] tie_mask;
    style    = $urandom_range(0, 3);
    fast     = ($urandom_range(0, 3) == 0);
    // a set bit makes that column a copy of its left neighbor for the run,
    // which forces tied column sums
    tie_mask = ($urandom_range(0, 3) == 0) ? NCOLS'($urandom_range(1, 7)) << 1 : '0;
    for (int r = 0; r < len; r++) begin
      for (int k = 0; k < NCOLS; k++) begin
        v[k] = pick_value(style);
        if (k > 0 && tie_mask[k]) v[k] = v[k-1];
      end
      offer_row(fast, CHR_W'($urandom_range(0, 255)), POS_W'($urandom),
                v[0], v[1], v[2], v[3], r == len - 1);
      if (r < ROWS) rows_stored++;
    end
  endtask

  // result sink: random stalls in stretches, some stretches with none, and
  // one long hold-off so the block backs up into its input
  initial begin : result_sink
    int stall;
    int stretch;
    bit steady;
    bit held;
    stretch = 0;
    steady  = 1'b0;
    held    = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (!held && rows_sent >= HOLD_AT) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (stretch == 0) begin
          stretch = $urandom_range(20, 80);
          steady  = ($urandom_range(0, 2) == 0);
        end
        stall = steady ? 0 : pick_gap();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ready <= 1'b1;
        @(posedge clk);
        stretch = (stretch > stall + 1) ? stretch - stall - 1 : 0;
      end
    end
  end

  initial begin : stimulus
    int run_no;
    int len;
    int roll;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single-row runs: empty downstream, four-way ties, field extremes
    offer_row(1'b0, 8'hFF, 32'hFFFF_FFFF, V_MAX, V_MAX, V_MAX, V_MAX, 1'b1);
    offer_row(1'b0, 8'h00, 32'h0000_0000, V_MIN, V_MIN, V_MIN, V_MIN, 1'b1);

    // each column takes its turn as the largest one
    offer_row(1'b0, 8'h5A, 32'h0000_0001, V_MAX, V_MIN, V_MIN, V_MIN, 1'b0);
    offer_row(1'b0, 8'hA5, 32'h8000_0000, V_MIN, V_MAX, V_MIN, V_MIN, 1'b0);
    offer_row(1'b0, 8'h01, 32'h7FFF_FFFF, V_MIN, V_MIN, V_MAX, V_MIN, 1'b0);
    offer_row(1'b0, 8'h80, 32'hAAAA_5555, V_MIN, V_MIN, V_MIN, V_MAX, 1'b1);

    // zero sums and partial ties, later column must not win a tie
    offer_row(1'b1, 8'h7F, 32'h5555_AAAA, 0, 0, 0, 0, 1'b0);
    offer_row(1'b1, 8'h10, 32'h0000_0010, -1, -1, 1, 1, 1'b0);
    offer_row(1'b1, 8'h20, 32'h0000_0020, 0, 2, 0, 2, 1'b1);

    // growing sums well past 32 bits in both directions
    for (int r = 0; r < 5; r++)
      offer_row(1'b0, CHR_W'(r + 3), POS_W'(r * 1000), V_MAX, V_MIN, 0, -1, r == 4);

    // random part: a full store and an overflowing run first, then mostly
    // short runs with a few medium ones and now and then one near the store size
    run_no = 0;
    while (rows_stored < ROW_TARGET) begin
      if (run_no == 0) begin
        len = ROWS;
      end else if (run_no == 1) begin
        len = ROWS + $urandom_range(1, 6);
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 80) len = $urandom_range(1, 8);
        else if (roll < 97) len = $urandom_range(9, 32);
        else len = $urandom_range(ROWS - 2, ROWS + 3);
      end
      send_run(len);
      run_no++;
    end
    in_valid <= 1'b0;

    // let every queued result come out, then watch for strays
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
